// File: rtl/waypoint_obstacle_cost_top_defines.svh
// Assertion macros for the waypoint obstacle cost block.
`ifndef WAYPOINT_OBSTACLE_COST_TOP_DEFINES_SVH
`define WAYPOINT_OBSTACLE_COST_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define WPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define WPC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WPC_ASSERT(lbl, prop, msg)
`define WPC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: rtl/wpc_pkg.sv
// Types and constants shared by the waypoint obstacle cost block.
package wpc_pkg;

	localparam int COORD_W   = 32;
	localparam int RAD_W     = 31;
	localparam int CNT_W     = 5;
	localparam int FIT_W     = 48;
	localparam int IDX_W     = 4;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 32;
	localparam int PEN_W     = 38;
	localparam int DIST_W    = 33;
	localparam int T_W       = 17;

	localparam logic [REG_IDX_W-1:0] REG_START_X   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_Y   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GOAL_X    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GOAL_Y    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_OBST_CNT  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CLEARANCE = 3'd5;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_SCORE = 1'b1;

	localparam logic [FIT_W-1:0] FIT_MAX    = 48'hFFFF_FFFF_FFFF;
	localparam logic [PEN_W-1:0] PEN_HIT    = 38'd6553600;
	localparam logic [65:0]      LEN_SQ_MIN = 66'd5;
	localparam logic [T_W-1:0]   T_ONE      = 17'h10000;

	localparam logic signed [COORD_W-1:0] GOAL_RST      = 32'sd196608;
	localparam logic [RAD_W-1:0]          CLEARANCE_RST = 31'd19661;

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN} state_t;
	typedef enum logic [1:0] {JOB_LEN_A, JOB_LEN_B, JOB_SEG_A, JOB_SEG_B} jobk_t;
	typedef enum logic [1:0] {T_ZERO, T_FULL, T_DIV} tsel_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [RAD_W-1:0]          r;
	} obst_t;

	typedef struct packed {
		logic  valid;
		jobk_t kind;
		logic  last;
		logic  first;
	} ctl_t;

	typedef struct packed {
		logic                      valid;
		logic                      is_len;
		logic                      last;
		logic                      first;
		logic signed [COORD_W-1:0] x1;
		logic signed [COORD_W-1:0] y1;
		logic signed [COORD_W-1:0] x2;
		logic signed [COORD_W-1:0] y2;
		logic signed [COORD_W-1:0] ox;
		logic signed [COORD_W-1:0] oy;
		logic [RAD_W-1:0]          r;
	} job_t;

	typedef struct packed {
		logic             valid;
		logic             is_len;
		logic             last;
		logic             first;
		logic [RAD_W-1:0] r;
	} carry_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic             first;
		logic [PEN_W-1:0] val;
	} res_t;

endpackage

// File: rtl/wpc_seg_pipe.sv
// Segment check pipeline: projection, divider, closest point, distance root, penalty.
module wpc_seg_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wpc_pkg::job_t                 job_i,
	input  logic [wpc_pkg::RAD_W-1:0]     clearance,
	output wpc_pkg::res_t                 res_o
);
	import wpc_pkg::*;

	carry_t c_s1, c_s2, c_s3;
	logic signed [32:0] dx_s1, dy_s1, ex_s1, ey_s1;
	logic signed [32:0] dx_s2, dy_s2, ex_s2, ey_s2;
	logic signed [32:0] dx_s3, dy_s3, ex_s3, ey_s3;
	logic signed [65:0] sqx_s2, sqy_s2, px_s2, py_s2;
	logic [65:0]        den_s3;
	logic signed [66:0] num_s3;

	carry_t             div_c   [0:16];
	tsel_t              div_ts  [0:16];
	logic [65:0]        div_rem [0:16];
	logic [15:0]        div_q   [0:16];
	logic [65:0]        div_den [0:15];
	logic signed [32:0] div_dx  [0:16];
	logic signed [32:0] div_dy  [0:16];
	logic signed [32:0] div_ex  [0:16];
	logic signed [32:0] div_ey  [0:16];

	logic [T_W-1:0]     t_fin;
	carry_t             c_s5, c_s6, c_s7;
	logic signed [50:0] tdx_s5, tdy_s5;
	logic signed [32:0] ex_s5, ey_s5;
	logic signed [34:0] shx, shy;
	logic signed [35:0] fxw, fyw;
	logic signed [33:0] fx_s6, fy_s6;
	logic signed [67:0] fxx_s7, fyy_s7;

	carry_t             sq_c    [0:33];
	logic [65:0]        sq_rem  [0:33];
	logic [32:0]        sq_root [0:33];

	carry_t             c_p1;
	logic               hit_p1, grade_p1;
	logic [31:0]        diff_p1, band;
	logic [DIST_W-1:0]  dist_p1;
	logic [PEN_W-1:0]   slope;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1 <= '0;
			c_s2 <= '0;
			c_s3 <= '0;
			div_c[0] <= '0;
		end else begin
			c_s1 <= '{job_i.valid, job_i.is_len, job_i.last, job_i.first, job_i.r};
			c_s2 <= c_s1;
			c_s3 <= c_s2;
			div_c[0] <= c_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= $signed({job_i.x2[31], job_i.x2}) - $signed({job_i.x1[31], job_i.x1});
		dy_s1 <= $signed({job_i.y2[31], job_i.y2}) - $signed({job_i.y1[31], job_i.y1});
		ex_s1 <= $signed({job_i.ox[31], job_i.ox}) - $signed({job_i.x1[31], job_i.x1});
		ey_s1 <= $signed({job_i.oy[31], job_i.oy}) - $signed({job_i.y1[31], job_i.y1});

		sqx_s2 <= dx_s1 * dx_s1;
		sqy_s2 <= dy_s1 * dy_s1;
		px_s2  <= dx_s1 * ex_s1;
		py_s2  <= dy_s1 * ey_s1;
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
		ex_s2 <= ex_s1;
		ey_s2 <= ey_s1;

		den_s3 <= $unsigned(sqx_s2) + $unsigned(sqy_s2);
		num_s3 <= px_s2 + py_s2;
		dx_s3 <= dx_s2;
		dy_s3 <= dy_s2;
		ex_s3 <= ex_s2;
		ey_s3 <= ey_s2;

		if (c_s3.is_len)
			div_ts[0] <= T_FULL;
		else if (den_s3 < LEN_SQ_MIN)
			div_ts[0] <= T_ZERO;
		else if (num_s3[66] || num_s3 == '0)
			div_ts[0] <= T_ZERO;
		else if (num_s3[65:0] >= den_s3)
			div_ts[0] <= T_FULL;
		else
			div_ts[0] <= T_DIV;
		div_rem[0] <= num_s3[65:0];
		div_q[0]   <= '0;
		div_den[0] <= den_s3;
		div_dx[0]  <= dx_s3;
		div_dy[0]  <= dy_s3;
		div_ex[0]  <= ex_s3;
		div_ey[0]  <= ey_s3;
	end

	for (genvar g = 0; g < 16; g++) begin : g_div
		logic [66:0] sh;
		logic        ge;
		assign sh = {div_rem[g], 1'b0};
		assign ge = sh >= {1'b0, div_den[g]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				div_c[g+1] <= '0;
			else
				div_c[g+1] <= div_c[g];
		end

		always_ff @(posedge clk) begin
			div_rem[g+1] <= ge ? 66'(sh - {1'b0, div_den[g]}) : sh[65:0];
			div_q[g+1]   <= {div_q[g][14:0], ge};
			div_ts[g+1]  <= div_ts[g];
			div_dx[g+1]  <= div_dx[g];
			div_dy[g+1]  <= div_dy[g];
			div_ex[g+1]  <= div_ex[g];
			div_ey[g+1]  <= div_ey[g];
		end

		if (g < 15) begin : g_den
			always_ff @(posedge clk) begin
				div_den[g+1] <= div_den[g];
			end
		end
	end

	always_comb begin
		case (div_ts[16])
			T_FULL:  t_fin = T_ONE;
			T_DIV:   t_fin = {1'b0, div_q[16]};
			default: t_fin = '0;
		endcase
	end

	assign shx = 35'(tdx_s5 >>> 16);
	assign shy = 35'(tdy_s5 >>> 16);
	assign fxw = shx - ex_s5;
	assign fyw = shy - ey_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s5 <= '0;
			c_s6 <= '0;
			c_s7 <= '0;
			sq_c[0] <= '0;
		end else begin
			c_s5 <= div_c[16];
			c_s6 <= c_s5;
			c_s7 <= c_s6;
			sq_c[0] <= c_s7;
		end
	end

	always_ff @(posedge clk) begin
		tdx_s5 <= $signed({1'b0, t_fin}) * div_dx[16];
		tdy_s5 <= $signed({1'b0, t_fin}) * div_dy[16];
		ex_s5  <= div_ex[16];
		ey_s5  <= div_ey[16];

		fx_s6 <= $signed(fxw[33:0]);
		fy_s6 <= $signed(fyw[33:0]);

		fxx_s7 <= fx_s6 * fx_s6;
		fyy_s7 <= fy_s6 * fy_s6;

		sq_rem[0]  <= $unsigned(fxx_s7[65:0]) + $unsigned(fyy_s7[65:0]);
		sq_root[0] <= '0;
	end

	for (genvar g = 0; g < 33; g++) begin : g_sqrt
		localparam int K = 32 - g;
		logic [67:0] trial;
		logic        ge;
		assign trial = (68'(sq_root[g]) << (K + 1)) | (68'(1) << (2 * K));
		assign ge    = {2'b00, sq_rem[g]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_c[g+1] <= '0;
			else
				sq_c[g+1] <= sq_c[g];
		end

		always_ff @(posedge clk) begin
			sq_rem[g+1]  <= ge ? 66'({2'b00, sq_rem[g]} - trial) : sq_rem[g];
			sq_root[g+1] <= ge ? (sq_root[g] | (33'(1) << K)) : sq_root[g];
		end
	end

	assign band  = 32'(sq_c[33].r) + 32'(clearance);
	assign slope = (38'(diff_p1) << 5) + (38'(diff_p1) << 4) + (38'(diff_p1) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_p1  <= '0;
			res_o <= '0;
		end else begin
			c_p1 <= sq_c[33];
			res_o.valid <= c_p1.valid;
			res_o.last  <= c_p1.last;
			res_o.first <= c_p1.first;
			if (c_p1.is_len)
				res_o.val <= 38'(dist_p1);
			else if (hit_p1)
				res_o.val <= PEN_HIT;
			else if (grade_p1)
				res_o.val <= slope;
			else
				res_o.val <= '0;
		end
	end

	always_ff @(posedge clk) begin
		dist_p1  <= sq_root[33];
		hit_p1   <= sq_root[33] < 33'(sq_c[33].r);
		grade_p1 <= sq_root[33] < 33'(band);
		diff_p1  <= band - sq_root[33][31:0];
	end

endmodule

// File: rtl/waypoint_obstacle_cost_top.sv
// Top level of the waypoint obstacle cost block: registers, obstacle table, sequencer, sum.
// A load (cmd 0) does not stall the input and writes one obstacle table entry. A score (cmd 1)
// issues 2 + 2*min(obstacle_count, MAX_OBSTACLES) segment checks, one per cycle, into a
// fully pipelined datapath 59 stages deep (16-stage divider for the projection,
// 33-stage square root for each distance). Input is stalled from a score's transfer
// until the sum has moved into the output register. The result may wait there while
// the next item is taken.
`include "waypoint_obstacle_cost_top_defines.svh"
module waypoint_obstacle_cost_top #(
	parameter int MAX_OBSTACLES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wpc_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [wpc_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic signed [wpc_pkg::COORD_W-1:0]  waypoint_x,
	input  logic signed [wpc_pkg::COORD_W-1:0]  waypoint_y,
	input  logic [wpc_pkg::IDX_W-1:0]           entry_index,
	input  logic signed [wpc_pkg::COORD_W-1:0]  centre_x,
	input  logic signed [wpc_pkg::COORD_W-1:0]  centre_y,
	input  logic [wpc_pkg::RAD_W-1:0]           radius,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [wpc_pkg::FIT_W-1:0]           fitness
);
	import wpc_pkg::*;

	localparam int IW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

	logic signed [COORD_W-1:0] start_x_q, start_y_q, goal_x_q, goal_y_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [RAD_W-1:0]          clr_q;

	obst_t mem [MAX_OBSTACLES];
	obst_t rd_q;
	logic [IW-1:0] rd_addr;

	state_t state_q, state_d;
	logic [5:0]       k_q, k_m2;
	logic [CNT_W-1:0] n_q;
	logic signed [COORD_W-1:0] wp_x_q, wp_y_q;
	logic             in_xfer, issue_last, move;
	ctl_t             ctl_s0;
	jobk_t            kind;
	job_t             job;
	res_t             res;

	logic [FIT_W-1:0] acc_q, acc_sat, fitness_q;
	logic [FIT_W:0]   acc_sum;
	logic             done_q, out_valid_q;

	assign in_xfer = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			goal_x_q  <= GOAL_RST;
			goal_y_q  <= GOAL_RST;
			cnt_q     <= '0;
			clr_q     <= CLEARANCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_X:   start_x_q <= cfg_data;
				REG_START_Y:   start_y_q <= cfg_data;
				REG_GOAL_X:    goal_x_q  <= cfg_data;
				REG_GOAL_Y:    goal_y_q  <= cfg_data;
				REG_OBST_CNT:  cnt_q     <= cfg_data[CNT_W-1:0];
				REG_CLEARANCE: clr_q     <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && cmd == CMD_LOAD && 32'(entry_index) < MAX_OBSTACLES)
			mem[IW'(entry_index)] <= '{centre_x, centre_y, radius};
		rd_q <= mem[rd_addr];
	end

	assign k_m2       = k_q - 6'd2;
	assign rd_addr    = IW'(k_m2[5:1]);
	assign issue_last = ({1'b0, k_q} == ({1'b0, n_q, 1'b0} + 7'd1));

	always_comb begin
		if (k_q == 6'd0)
			kind = JOB_LEN_A;
		else if (k_q == 6'd1)
			kind = JOB_LEN_B;
		else if (k_m2[0])
			kind = JOB_SEG_B;
		else
			kind = JOB_SEG_A;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && cmd == CMD_SCORE)
					state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (issue_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (move)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			n_q    <= '0;
			ctl_s0 <= '0;
		end else begin
			if (state_q == ST_IDLE && in_xfer && cmd == CMD_SCORE) begin
				k_q <= '0;
				n_q <= (32'(cnt_q) > MAX_OBSTACLES) ? CNT_W'(MAX_OBSTACLES) : cnt_q;
			end else if (state_q == ST_ISSUE) begin
				k_q <= k_q + 6'd1;
			end
			ctl_s0.valid <= (state_q == ST_ISSUE);
			ctl_s0.kind  <= kind;
			ctl_s0.last  <= issue_last;
			ctl_s0.first <= (k_q == 6'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer && cmd == CMD_SCORE) begin
			wp_x_q <= waypoint_x;
			wp_y_q <= waypoint_y;
		end
	end

	always_comb begin
		job.valid  = ctl_s0.valid;
		job.last   = ctl_s0.last;
		job.first  = ctl_s0.first;
		job.is_len = 1'b0;
		job.ox     = rd_q.cx;
		job.oy     = rd_q.cy;
		job.r      = rd_q.r;
		case (ctl_s0.kind)
			JOB_LEN_A: begin
				job.x1 = start_x_q; job.y1 = start_y_q;
				job.x2 = wp_x_q;    job.y2 = wp_y_q;
				job.ox = start_x_q; job.oy = start_y_q;
				job.is_len = 1'b1;
			end
			JOB_LEN_B: begin
				job.x1 = wp_x_q;   job.y1 = wp_y_q;
				job.x2 = goal_x_q; job.y2 = goal_y_q;
				job.ox = wp_x_q;   job.oy = wp_y_q;
				job.is_len = 1'b1;
			end
			JOB_SEG_A: begin
				job.x1 = start_x_q; job.y1 = start_y_q;
				job.x2 = wp_x_q;    job.y2 = wp_y_q;
			end
			default: begin
				job.x1 = wp_x_q;   job.y1 = wp_y_q;
				job.x2 = goal_x_q; job.y2 = goal_y_q;
			end
		endcase
	end

	wpc_seg_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_i     (job),
		.clearance (clr_q),
		.res_o     (res)
	);

	assign acc_sum = {1'b0, acc_q} + 49'(res.val);
	assign acc_sat = (acc_sum > {1'b0, FIT_MAX}) ? FIT_MAX : acc_sum[FIT_W-1:0];
	assign move    = done_q && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (res.valid)
			acc_q <= res.first ? 48'(res.val) : acc_sat;
		if (move)
			fitness_q <= acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (res.valid && res.last)
				done_q <= 1'b1;
			else if (move)
				done_q <= 1'b0;
			if (move)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign fitness   = fitness_q;

	`WPC_ASSERT(a_idle_no_result, (state_q == ST_IDLE) |-> !res.valid, "pipeline result while idle")
	`WPC_ASSERT(a_issue_stops, ctl_s0.valid && ctl_s0.last |=> !ctl_s0.valid, "issue past last job")
	`WPC_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(done_q), "output without finished sum")
	`WPC_ASSERT_RST(a_rst_clear, !arst_n |=> !out_valid_q && !done_q, "control not cleared in reset")

endmodule

// File: dv/tb_waypoint_obstacle_cost_top.sv
// Self-checking testbench for the waypoint obstacle cost block: queued stimulus, scoring model.
module tb_waypoint_obstacle_cost_top;
	import wpc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_OBST = 16;
	localparam int SETTLE   = 120;

	typedef struct {
		logic                      cmd;
		logic signed [COORD_W-1:0] wx;
		logic signed [COORD_W-1:0] wy;
		logic [IDX_W-1:0]          idx;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [RAD_W-1:0]          r;
	} wp_item_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_W-1:0]          cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      cmd = CMD_LOAD;
	logic signed [COORD_W-1:0] waypoint_x = '0;
	logic signed [COORD_W-1:0] waypoint_y = '0;
	logic [IDX_W-1:0]          entry_index = '0;
	logic signed [COORD_W-1:0] centre_x = '0;
	logic signed [COORD_W-1:0] centre_y = '0;
	logic [RAD_W-1:0]          radius = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [FIT_W-1:0]          fitness;

	waypoint_obstacle_cost_top DUT (.*);

	// scoring model state
	logic signed [63:0] m_sx, m_sy, m_gx, m_gy;
	logic [4:0]         m_count;
	logic [63:0]        m_clear;
	logic signed [63:0] m_ox [NUM_OBST];
	logic signed [63:0] m_oy [NUM_OBST];
	logic [63:0]        m_rad [NUM_OBST];

	wp_item_t         pend_q[$];
	logic [FIT_W-1:0] fitness_q[$];
	wp_item_t         cur;
	int               in_gap = 0, out_gap = 0;
	bit               quiet = 0;
	int               errors = 0, n_scores = 0, n_loads = 0, n_phases = 0;

	initial forever #4 clk = ~clk;

	function automatic logic [63:0] isqrt(logic [127:0] v);
		logic [63:0]  res;
		logic [63:0]  c;
		logic [127:0] sq;
		res = '0;
		for (int k = 34; k >= 0; k--) begin
			c = res | (64'd1 << k);
			sq = c * c;
			if (sq <= v) res = c;
		end
		return res;
	endfunction

	function automatic logic [127:0] sum_sq(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [127:0] a2, b2;
		a2 = 128'(a) * 128'(a);
		b2 = 128'(b) * 128'(b);
		return a2 + b2;
	endfunction

	function automatic logic [63:0] seg_cost(logic signed [63:0] x1, logic signed [63:0] y1,
			logic signed [63:0] x2, logic signed [63:0] y2, logic signed [63:0] ox,
			logic signed [63:0] oy, logic [63:0] r);
		logic signed [63:0]  dx, dy, t, cxp, cyp;
		logic signed [127:0] den, num;
		logic [127:0]        q;
		logic [63:0]         seg_dist, band;
		dx = x2 - x1;
		dy = y2 - y1;
		den = sum_sq(dx, dy);
		num = 128'(ox - x1) * 128'(dx) + 128'(oy - y1) * 128'(dy);
		t = 0;
		if (den >= 5) begin
			if (num <= 0) t = 0;
			else if (num >= den) t = 65536;
			else begin
				q = (128'(num) << 16) / 128'(den);
				t = 64'(q);
			end
		end
		cxp = x1 + ((t * dx) >>> 16);
		cyp = y1 + ((t * dy) >>> 16);
		seg_dist = isqrt(sum_sq(cxp - ox, cyp - oy));
		band = r + m_clear;
		if (seg_dist < r) return 64'd6553600;
		if (seg_dist < band) return 64'd50 * (band - seg_dist);
		return 0;
	endfunction

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > 64'(FIT_MAX)) ? 64'(FIT_MAX) : s;
	endfunction

	task automatic predict_cost(wp_item_t it);
		logic signed [63:0] wx, wy;
		logic [63:0]        fit;
		int                 n;
		if (it.cmd == CMD_LOAD) begin
			m_ox[it.idx] = it.cx;
			m_oy[it.idx] = it.cy;
			m_rad[it.idx] = 64'(it.r);
			n_loads++;
		end else begin
			wx = it.wx;
			wy = it.wy;
			fit = isqrt(sum_sq(wx - m_sx, wy - m_sy));
			fit = sat_sum(fit, isqrt(sum_sq(m_gx - wx, m_gy - wy)));
			n = (m_count > NUM_OBST) ? NUM_OBST : m_count;
			for (int i = 0; i < n; i++) begin
				fit = sat_sum(fit, seg_cost(m_sx, m_sy, wx, wy, m_ox[i], m_oy[i], m_rad[i]));
				fit = sat_sum(fit, seg_cost(wx, wy, m_gx, m_gy, m_ox[i], m_oy[i], m_rad[i]));
			end
			fitness_q = {fitness_q, fit[FIT_W-1:0]};
		end
	endtask

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) predict_cost(cur);
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pend_q.size() > 0) begin
					cur = pend_q.pop_front();
					cmd <= cur.cmd;
					waypoint_x <= cur.wx;
					waypoint_y <= cur.wy;
					entry_index <= cur.idx;
					centre_x <= cur.cx;
					centre_y <= cur.cy;
					radius <= cur.r;
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor and stall generator
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (fitness_q.size() == 0) begin
					$display("%0t: unexpected fitness transfer, expected none, actual %0h",
						$time, fitness);
					errors++;
				end else begin
					if (fitness !== fitness_q[0]) begin
						$display("%0t: fitness mismatch, expected %0h, actual %0h",
							$time, fitness_q[0], fitness);
						errors++;
					end
					void'(fitness_q.pop_front());
					n_scores++;
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_gap <= $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 20) * 32768 - 327680;
			default: return int'($urandom_range(0, 1310720)) - 655360;
		endcase
	endfunction

	function automatic logic [RAD_W-1:0] rand_rad();
		case ($urandom_range(0, 5))
			0: return RAD_W'($urandom);
			1: return '0;
			default: return RAD_W'($urandom_range(0, 196608));
		endcase
	endfunction

	function automatic wp_item_t mk_load(int i, logic signed [31:0] x, logic signed [31:0] y,
			logic [RAD_W-1:0] r);
		wp_item_t it;
		it.cmd = CMD_LOAD;
		it.wx = $urandom;
		it.wy = $urandom;
		it.idx = IDX_W'(i);
		it.cx = x;
		it.cy = y;
		it.r = r;
		return it;
	endfunction

	function automatic wp_item_t mk_score(logic signed [31:0] x, logic signed [31:0] y);
		wp_item_t it;
		it.cmd = CMD_SCORE;
		it.wx = x;
		it.wy = y;
		it.idx = IDX_W'($urandom);
		it.cx = $urandom;
		it.cy = $urandom;
		it.r = RAD_W'($urandom);
		return it;
	endfunction

	task automatic queue_item(wp_item_t it);
		pend_q = {pend_q, it};
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pend_q.size() != 0 || in_valid || fitness_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_START_X:   m_sx = $signed(val);
			REG_START_Y:   m_sy = $signed(val);
			REG_GOAL_X:    m_gx = $signed(val);
			REG_GOAL_Y:    m_gy = $signed(val);
			REG_OBST_CNT:  m_count = val[4:0];
			REG_CLEARANCE: m_clear = 64'(val[30:0]);
			default: ;
		endcase
	endtask

	task automatic set_config(logic [31:0] sx, logic [31:0] sy, logic [31:0] gx,
			logic [31:0] gy, logic [31:0] cnt, logic [31:0] clr);
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_GOAL_X, gx);
		write_reg(REG_GOAL_Y, gy);
		write_reg(REG_OBST_CNT, cnt);
		write_reg(REG_CLEARANCE, clr);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_phases++;
	endtask

	task automatic push_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				queue_item(mk_load($urandom_range(0, 15), rand_coord(), rand_coord(),
					rand_rad()));
			else if ($urandom_range(0, 9) == 0)
				queue_item(mk_score(32'(m_sx), 32'(m_sy)));
			else
				queue_item(mk_score(rand_coord(), rand_coord()));
		end
	endtask

	initial begin
		m_sx = 0;
		m_sy = 0;
		m_gx = 196608;
		m_gy = 196608;
		m_count = 0;
		m_clear = 19661;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, no obstacles scored; then fill the whole table
		queue_item(mk_score(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		queue_item(mk_score(32'sh8000_0000, 32'sh8000_0000));
		queue_item(mk_score(0, 0));
		queue_item(mk_load(0, 65536, 65536, 32768));
		queue_item(mk_load(1, 131072, 65536, 13107));
		queue_item(mk_load(2, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF));
		queue_item(mk_load(3, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
		for (int i = 4; i < NUM_OBST; i++)
			queue_item(mk_load(i, rand_coord(), rand_coord(), rand_rad()));
		wait_idle();

		set_config(0, 0, 196608, 196608, 2, 19661);
		queue_item(mk_score(65536, 65536));
		queue_item(mk_score(0, 0));
		queue_item(mk_score(196608, 0));
		queue_item(mk_score(32'sh7FFF_FFFF, 32'sh8000_0000));
		queue_item(mk_load(1, 98304, 0, 6553));
		queue_item(mk_score(131072, 0));
		wait_idle();

		set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31,
			32'h7FFF_FFFF);
		queue_item(mk_score(32'sh8000_0000, 32'sh7FFF_FFFF));
		queue_item(mk_score(0, 0));
		queue_item(mk_score(32'sh7FFF_FFFF, 32'sh8000_0000));
		wait_idle();

		set_config(65536, 65536, 65536, 65537, 16, 0);
		queue_item(mk_score(65536, 65536));
		queue_item(mk_score(65538, 65536));
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			set_config(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				(p % 3 == 0) ? $urandom_range(0, 31) : $urandom_range(0, 16),
				(p == 2) ? $urandom : $urandom_range(0, 131072));
			if (p == 7) quiet = 1;
			push_random(120);
			wait_idle();
		end

		$display("Covered %0d loads and %0d scored waypoints over %0d register settings.",
			n_loads, n_scores, n_phases);
		$display("Mismatches: %0d", errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d results outstanding", fitness_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
